/* hdl/tbpc_pkg.sv */
// Shared types and constants for the two-button press classifier.
`default_nettype none

package tbpc_pkg;

   localparam int unsigned RELOAD_W = 16;
   localparam int unsigned REPORT_W = 3;

   localparam logic [RELOAD_W-1:0] DEBOUNCE_RELOAD_RST = 16'd150;
   localparam logic [RELOAD_W-1:0] HOLD_RELOAD_RST     = 16'd300;

   // Register indexes on the configuration port.
   localparam logic CSR_DEBOUNCE_RELOAD = 1'b0;
   localparam logic CSR_HOLD_RELOAD     = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_DEBOUNCE = 4'b0010,
      PH_HOLD1    = 4'b0100,
      PH_HOLD2    = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      FP_NONE = 2'd0,
      FP_UP   = 2'd1,
      FP_DOWN = 2'd2
   } first_press_type;

   localparam logic [REPORT_W-1:0] REP_NONE      = 3'd0;
   localparam logic [REPORT_W-1:0] REP_UP        = 3'd1;
   localparam logic [REPORT_W-1:0] REP_DOWN      = 3'd2;
   localparam logic [REPORT_W-1:0] REP_UP_LONG   = 3'd3;
   localparam logic [REPORT_W-1:0] REP_DOWN_LONG = 3'd4;
   localparam logic [REPORT_W-1:0] REP_BOTH      = 3'd5;

   typedef struct packed {
      logic [RELOAD_W-1:0] debounce_reload;
      logic [RELOAD_W-1:0] hold_reload;
   } cfg_type;

   typedef struct packed {
      logic                up_level;
      logic                down_level;
      logic                tick;
   } sample_type;

   typedef struct packed {
      logic [REPORT_W-1:0] press_report;
      logic                busy_res;
   } result_type;

endpackage

`default_nettype wire

/* hdl/tbpc_csr.sv */
// Configuration registers: debounce and hold reload values.
`default_nettype none

module tbpc_csr
   import tbpc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_addr,
   input  wire logic [RELOAD_W-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_reload <= DEBOUNCE_RELOAD_RST;
         cfg_ff.hold_reload     <= HOLD_RELOAD_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEBOUNCE_RELOAD: cfg_ff.debounce_reload <= csr_wdata;
            CSR_HOLD_RELOAD:     cfg_ff.hold_reload     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hdl/tbpc_core.sv */
// Classifier state and its one-step update; gives the result of each step.
`default_nettype none

module tbpc_core
   import tbpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire sample_type sample,
   input  wire cfg_type    cfg,
   output result_type      result
);

   phase_type           phase_ff, phase_in;
   logic [RELOAD_W-1:0] tick_count_ff, tick_count_in;
   logic                pending_up_ff, pending_up_in;
   logic                pending_down_ff, pending_down_in;
   logic [1:0]          last_levels_ff, last_levels_in;
   first_press_type     first_press_ff, first_press_in;
   logic [REPORT_W-1:0] reported_ff, reported_in;

   logic                up_held;
   logic                down_held;
   logic [RELOAD_W-1:0] reload;
   logic                period_end;

   assign up_held   = ~sample.up_level;
   assign down_held = ~sample.down_level;
   assign reload    = (phase_ff == PH_DEBOUNCE) ? cfg.debounce_reload : cfg.hold_reload;
   assign period_end = sample.tick && (tick_count_ff == reload);

   always_comb begin
      // latch falling edges before the period logic
      pending_up_in   = pending_up_ff   | (last_levels_ff[0] & up_held);
      pending_down_in = pending_down_ff | (last_levels_ff[1] & down_held);
      last_levels_in  = {sample.down_level, sample.up_level};
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      first_press_in  = first_press_ff;
      reported_in     = reported_ff;

      if (phase_ff != PH_IDLE && sample.tick) begin
         tick_count_in = period_end ? '0 : tick_count_ff + RELOAD_W'(1);
      end

      case (phase_ff)
         PH_IDLE: begin
            if (pending_up_in || pending_down_in) begin
               phase_in      = PH_DEBOUNCE;
               tick_count_in = '0;
            end
         end
         PH_DEBOUNCE: begin
            if (period_end) begin
               if (pending_up_in && pending_down_in && up_held && down_held) begin
                  pending_up_in   = 1'b0;
                  pending_down_in = 1'b0;
                  reported_in     = REP_BOTH;
                  phase_in        = PH_HOLD1;
               end else if (pending_up_in && up_held) begin
                  pending_up_in  = 1'b0;
                  first_press_in = FP_UP;
                  phase_in       = PH_HOLD1;
               end else if (pending_down_in && down_held) begin
                  pending_down_in = 1'b0;
                  first_press_in  = FP_DOWN;
                  phase_in        = PH_HOLD1;
               end else begin
                  reported_in     = REP_NONE;
                  first_press_in  = FP_NONE;
                  pending_up_in   = 1'b0;
                  pending_down_in = 1'b0;
                  phase_in        = PH_IDLE;
               end
            end
         end
         PH_HOLD1: begin
            if (period_end) begin
               if (up_held) begin
                  reported_in    = REP_UP_LONG;
                  first_press_in = FP_NONE;
               end else if (down_held) begin
                  reported_in    = REP_DOWN_LONG;
                  first_press_in = FP_NONE;
               end else if (first_press_ff == FP_DOWN) begin
                  reported_in    = REP_DOWN;
                  first_press_in = FP_NONE;
               end else if (first_press_ff == FP_UP) begin
                  reported_in    = REP_UP;
                  first_press_in = FP_NONE;
               end
               phase_in = PH_HOLD2;
            end
         end
         default: begin
            if (period_end) begin
               pending_up_in   = 1'b0;
               pending_down_in = 1'b0;
               first_press_in  = FP_NONE;
               phase_in        = PH_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= '0;
         pending_up_ff   <= 1'b0;
         pending_down_ff <= 1'b0;
         last_levels_ff  <= 2'b11;
         first_press_ff  <= FP_NONE;
         reported_ff     <= REP_NONE;
      end else if (step) begin
         phase_ff        <= phase_in;
         tick_count_ff   <= tick_count_in;
         pending_up_ff   <= pending_up_in;
         pending_down_ff <= pending_down_in;
         last_levels_ff  <= last_levels_in;
         first_press_ff  <= first_press_in;
         reported_ff     <= reported_in;
      end
   end

   assign result.press_report = reported_in;
   assign result.busy_res     = (phase_in != PH_IDLE);

`ifndef SYNTHESIS
   a_clear_on_idle: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_HOLD2 && phase_in == PH_IDLE
      |=> !pending_up_ff && !pending_down_ff && first_press_ff == FP_NONE)
      else $error("pending flags not cleared on return to idle");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(tick_count_ff) && $stable(reported_ff))
      else $error("state moved without a step");

   a_report_range: assert property (@(posedge clock) disable iff (reset)
      reported_ff <= REP_BOTH)
      else $error("press report out of range");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && phase_in == PH_DEBOUNCE |=> tick_count_ff == '0)
      else $error("debounce started with a stale count");
`endif

endmodule

`default_nettype wire

/* hdl/two_button_press_classifier.sv */
// Top level of the two-button press classifier: stream ports, sample and result registers.
// Path: a transfer on req_ is registered in the sample register; a step then moves it into
//   the classifier state and loads the result register, which offers the result on rsp_;
//   the step waits while the result register holds a result that is not being taken.
// Throughput: one item per cycle; the sample register and the result register form a
//   two-stage pipeline that advances whenever the result register is free or being taken.
// Reset: synchronous, active high; clears both valid flags, the classifier state (idle,
//   buttons released, nothing reported) and loads the reload registers with 150 and 300.
`default_nettype none

module two_button_press_classifier
   import tbpc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input samples
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [0] up_level, [1] down_level, [2] tick
   // classification results
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [7:0]               rsp_tdata,   // [2:0] press_report, [3] busy_res
   // configuration writes
   input  wire logic                csr_we,
   input  wire logic                csr_addr,
   input  wire logic [RELOAD_W-1:0] csr_wdata
);

   logic       smp_valid_ff;
   sample_type smp_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic       out_free;
   logic       step;
   cfg_type    cfg;
   result_type result;

   // The result register can take a new value when empty or when its transfer completes.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   // Advance the sample held in the input register into the classifier.
   assign step       = smp_valid_ff && out_free;
   // Accept a new sample whenever the input register is empty or moves on this cycle.
   assign req_tready = !smp_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         smp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         smp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         smp_ff.up_level   <= req_tdata[0];
         smp_ff.down_level <= req_tdata[1];
         smp_ff.tick       <= req_tdata[2];
      end
   end

   tbpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tbpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .sample (smp_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Hold the result until the downstream side takes it; load a fresh one on each step.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.busy_res, rsp_ff.press_report};

endmodule

`default_nettype wire
